[src/mqtt_fixed_header_framer_top_macros.svh]
`ifndef MQTT_FIXED_HEADER_FRAMER_TOP_MACROS_SVH
`define MQTT_FIXED_HEADER_FRAMER_TOP_MACROS_SVH

// checked only outside reset
`define MFHF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define MFHF_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[src/mfhf_pkg.sv]
package mfhf_pkg;

  localparam int unsigned MAX_LENGTH_BYTES = 4;
  localparam int unsigned LEN_W = 28;

  localparam logic [3:0] TYPE_RESERVED = 4'h0;
  localparam logic [3:0] TYPE_INVALID  = 4'hF;

  typedef enum logic [1:0] {
    PH_TYPE = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2,
    PH_DROP = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ROLE_TYPE = 2'd0,
    ROLE_LEN  = 2'd1,
    ROLE_BODY = 2'd2,
    ROLE_DROP = 2'd3
  } role_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_UNKNOWN  = 2'd1,
    ERR_BAD_LEN  = 2'd2
  } err_e;

  typedef struct packed {
    phase_e             phase;
    logic [3:0]         ptype;
    logic [3:0]         flags;
    logic [LEN_W-1:0]   acc;
    logic [2:0]         cnt;
    logic [LEN_W-1:0]   left;
  } state_t;

  typedef struct packed {
    role_e              role;
    logic [3:0]         ptype;
    logic [3:0]         flags;
    logic [LEN_W-1:0]   rlen;
    logic               len_valid;
    logic [7:0]         data;
    logic               pend;
    err_e               err;
  } result_t;

  localparam state_t STATE_RESET = '{
    phase: PH_TYPE,
    ptype: 4'h0,
    flags: 4'h0,
    acc:   '0,
    cnt:   3'd0,
    left:  '0
  };

endpackage

[src/mfhf_in_if.sv]
interface mfhf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_connection;

  modport source (output valid, output data_byte, output start_of_connection, input ready);
  modport sink   (input valid, input data_byte, input start_of_connection, output ready);
endinterface

[src/mfhf_out_if.sv]
interface mfhf_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  byte_role;
  logic [3:0]  msg_type;
  logic [3:0]  header_flags;
  logic [27:0] remaining_length;
  logic        length_valid;
  logic [7:0]  body_data;
  logic        packet_end;
  logic [1:0]  error_code;

  modport source (
    output valid, output byte_role, output msg_type, output header_flags,
    output remaining_length, output length_valid, output body_data,
    output packet_end, output error_code, input ready
  );
  modport sink (
    input valid, input byte_role, input msg_type, input header_flags,
    input remaining_length, input length_valid, input body_data,
    input packet_end, input error_code, output ready
  );
endinterface

[src/mfhf_step.sv]
module mfhf_step
  import mfhf_pkg::*;
(
  input  state_t     state_i,
  input  logic [7:0] data_i,
  input  logic       soc_i,
  output state_t     state_o,
  output result_t    res_o
);

  state_t           s;
  state_t           nxt;
  result_t          res;
  logic [LEN_W-1:0] shifted;
  logic [LEN_W-1:0] acc_sum;

  always_comb begin
    case (s.cnt[1:0])
      2'd0:    shifted = {21'd0, data_i[6:0]};
      2'd1:    shifted = {14'd0, data_i[6:0], 7'd0};
      2'd2:    shifted = {7'd0, data_i[6:0], 14'd0};
      default: shifted = {data_i[6:0], 21'd0};
    endcase
    acc_sum = s.acc + shifted;
  end

  always_comb begin
    s   = soc_i ? STATE_RESET : state_i;
    nxt = s;
    res = '{role: ROLE_TYPE, ptype: 4'h0, flags: 4'h0, rlen: '0, len_valid: 1'b0,
            data: data_i, pend: 1'b0, err: ERR_NONE};
    case (s.phase)
      PH_TYPE: begin
        nxt.ptype = data_i[7:4];
        nxt.flags = data_i[3:0];
        nxt.acc   = '0;
        nxt.cnt   = 3'd0;
        nxt.left  = '0;
        if (data_i[7:4] inside {TYPE_RESERVED, TYPE_INVALID}) begin
          res.err   = ERR_UNKNOWN;
          nxt.phase = PH_DROP;
        end else begin
          nxt.phase = PH_LEN;
        end
      end
      PH_LEN: begin
        res.role = ROLE_LEN;
        if (s.cnt >= 3'(MAX_LENGTH_BYTES)) begin
          res.err   = ERR_BAD_LEN;
          nxt.phase = PH_DROP;
        end else begin
          nxt.acc = acc_sum;
          nxt.cnt = 3'(s.cnt + 3'd1);
          if (!data_i[7]) begin
            res.len_valid = 1'b1;
            res.rlen      = acc_sum;
            if (acc_sum == '0) begin
              res.pend  = 1'b1;
              nxt.phase = PH_TYPE;
            end else begin
              nxt.left  = acc_sum;
              nxt.phase = PH_BODY;
            end
          end
        end
      end
      PH_BODY: begin
        res.role      = ROLE_BODY;
        res.len_valid = 1'b1;
        res.rlen      = s.acc;
        nxt.left      = s.left - LEN_W'(1);
        if (nxt.left == '0) begin
          res.pend  = 1'b1;
          nxt.phase = PH_TYPE;
        end
      end
      default: begin
        res.role = ROLE_DROP;
      end
    endcase
    res.ptype = nxt.ptype;
    res.flags = nxt.flags;
  end

  assign state_o = nxt;
  assign res_o   = res;

endmodule

[src/mqtt_fixed_header_framer_top.sv]
// Each result is registered and appears in the cycle after its byte is transferred in.
// Throughput: one byte per cycle; the single result register stalls the
// input only while it holds a result the sink has not taken.
// Reset (rst_ni low, asynchronous): framer returns to expecting a type byte,
// all counters cleared, output register empty.
`include "mqtt_fixed_header_framer_top_macros.svh"

module mqtt_fixed_header_framer_top
  import mfhf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  mfhf_in_if.sink           in_i,
  mfhf_out_if.source        out_o
);

  state_t  state_q, state_d;
  result_t res_q, res_d;
  logic    out_valid_q;
  logic    in_xfer;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_xfer    = in_i.valid && in_i.ready;

  mfhf_step u_step (
    .state_i (state_q),
    .data_i  (in_i.data_byte),
    .soc_i   (in_i.start_of_connection),
    .state_o (state_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= STATE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.byte_role        = res_q.role;
  assign out_o.msg_type         = res_q.ptype;
  assign out_o.header_flags     = res_q.flags;
  assign out_o.remaining_length = res_q.rlen;
  assign out_o.length_valid     = res_q.len_valid;
  assign out_o.body_data        = res_q.data;
  assign out_o.packet_end       = res_q.pend;
  assign out_o.error_code       = res_q.err;

  `MFHF_ASSERT_RST(a_err_role,
    out_o.valid && (out_o.error_code != ERR_NONE) |->
      (out_o.byte_role == ROLE_TYPE) || (out_o.byte_role == ROLE_LEN),
    "error flagged on a body or dropped byte")
  `MFHF_ASSERT_RST(a_end_len,
    out_o.valid && out_o.packet_end |-> out_o.length_valid,
    "packet end without a complete length")
  `MFHF_ASSERT_RST(a_drop_stays,
    in_xfer && !in_i.start_of_connection && (state_q.phase == PH_DROP) |=>
      out_o.valid && (out_o.byte_role == ROLE_DROP),
    "byte not dropped after error")
  `MFHF_ASSERT_ANY(a_rst_empty,
    !rst_ni |-> !out_o.valid,
    "result pending during reset")

endmodule
